@@ hdl/bkg_pkg.sv @@
// Shared types and constants for the block reverse k-group core.
package bkg_pkg;

  localparam int CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] GROUP_SIZE_RESET = CFG_BITS'(1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept;  // take the input item, store it, arm a flush if due
    logic load;    // move the next buffered value into the output register
  } cmd_t;

  typedef struct packed {
    logic flush;     // the incoming item closes a group or the sequence
    logic final_ld;  // the next load is the last of the flush
    logic out_free;  // output register can take a new item this cycle
  } status_t;

endpackage

@@ hdl/block_reverse_k_group_core.sv @@
// Top level of the block reverse k-group core.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one value per item with a
//   last flag. Values are buffered until group_size of them are held; the
//   group then streams out in reverse order. A sequence that ends on a
//   partial group streams out in arrival order. out_last_o marks the final
//   item of the sequence.
//   group_size is written through cfg_we_i / cfg_wdata_i while idle; 0 acts
//   as 1, values above MAX_GROUP act as MAX_GROUP.
// Flow:
//   An item that does not close a group is taken without stalling the input. An
//   item that closes a group of n values is taken, then the n results leave
//   one per cycle while out_stall_i allows, through the output register
//   (single-port group store read); the input stalls until the last of them
//   is loaded into the output register. The first result passes through the
//   ST_EMIT state and then the output register.
// Reset clears the fill count and output valid and sets group_size to 1.
// While out_stall_i is high and an output item is valid, the item holds and the flush pauses.
module block_reverse_k_group_core #(
  parameter int MAX_GROUP = 16,
  parameter int DATA_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bkg_pkg::CFG_BITS-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [DATA_BITS-1:0]         item_value_i,
  input  logic                         item_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [DATA_BITS-1:0]         out_value_o,
  output logic                         out_last_o
);
  import bkg_pkg::*;

  cmd_t    cmd;
  status_t status;

  bkg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bkg_dpath #(
    .MAX_GROUP (MAX_GROUP),
    .DATA_BITS (DATA_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_value_i (item_value_i),
    .item_last_i  (item_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .out_last_o   (out_last_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

@@ hdl/bkg_ctrl.sv @@
// Controller state machine: accepts items and sequences the flush of a group.
module bkg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bkg_pkg::status_t status_i,
  output bkg_pkg::cmd_t    cmd_o
);
  import bkg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.flush) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free && status_i.final_ld) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_EMIT: begin
        cmd_o.load = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
        cmd_o      = '0;
      end
    endcase
  end

  a_no_accept_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !cmd_o.accept)
    else $error("item accepted during flush");

  a_flush_enters_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.flush) |=> (state_q == ST_EMIT))
    else $error("flush not started");

  a_load_exits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && status_i.final_ld) |=> (state_q == ST_IDLE))
    else $error("flush did not end after final load");

endmodule

@@ hdl/bkg_dpath.sv @@
// Datapath: group store, fill count, flush pointer and output register.
module bkg_dpath #(
  parameter int MAX_GROUP = 16,
  parameter int DATA_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bkg_pkg::CFG_BITS-1:0] cfg_wdata_i,
  input  logic [DATA_BITS-1:0]         item_value_i,
  input  logic                         item_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [DATA_BITS-1:0]         out_value_o,
  output logic                         out_last_o,
  input  bkg_pkg::cmd_t                cmd_i,
  output bkg_pkg::status_t             status_o
);
  import bkg_pkg::*;

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int KW = (CW > CFG_BITS) ? CW : CFG_BITS;

  logic [CFG_BITS-1:0]  group_size_q;
  logic [CW-1:0]        fill_q, fill_d;
  logic [CW-1:0]        remain_q;
  logic [CW-1:0]        ptr_q;
  logic                 rev_q;
  logic                 last_q;
  logic                 out_valid_q;
  logic [DATA_BITS-1:0] out_value_q;
  logic                 out_last_q;
  logic [DATA_BITS-1:0] mem [MAX_GROUP];

  logic [KW-1:0] gs_ext, k_eff, n_ext;
  logic [CW-1:0] n_cnt;
  logic          full_grp;

  always_comb begin
    gs_ext = KW'(group_size_q);
    k_eff  = gs_ext;
    if (gs_ext == '0) begin
      k_eff = KW'(1);
    end else if (gs_ext > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end
    n_cnt    = fill_q + CW'(1);
    n_ext    = KW'(n_cnt);
    full_grp = (n_ext >= k_eff);
  end

  assign status_o.flush    = full_grp || item_last_i;
  assign status_o.final_ld = (remain_q == CW'(1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.accept) begin
      fill_d = status_o.flush ? '0 : n_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GROUP_SIZE_RESET;
      fill_q       <= '0;
      remain_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
      fill_q <= fill_d;
      if (cmd_i.accept && status_o.flush) begin
        remain_q <= n_cnt;
      end else if (cmd_i.load) begin
        remain_q <= remain_q - CW'(1);
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[fill_q[AW-1:0]] <= item_value_i;
      if (status_o.flush) begin
        rev_q  <= full_grp;
        last_q <= item_last_i;
        ptr_q  <= full_grp ? fill_q : '0;
      end
    end else if (cmd_i.load) begin
      ptr_q <= rev_q ? (ptr_q - CW'(1)) : (ptr_q + CW'(1));
    end
    if (cmd_i.load) begin
      out_value_q <= mem[ptr_q[AW-1:0]];
      out_last_q  <= last_q && (remain_q == CW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CW'(MAX_GROUP))
    else $error("fill count out of range");

  a_load_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (remain_q != '0))
    else $error("load with nothing buffered");

  a_accept_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !cmd_i.load)
    else $error("accept and load together");

  a_flush_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && status_o.flush) |=> (remain_q != '0 && fill_q == '0))
    else $error("flush not armed");

endmodule
